// ----- rtl/core/pvio_pkg.sv -----
// Shared types and constants for the plane memory I/O decoder.
package pvio_pkg;

  localparam int unsigned NUM_PLANES    = 3;
  localparam int unsigned ADDR_W        = 16;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned QUARTER_LSB   = 14;
  localparam int unsigned IN_OFS_W      = 14;
  localparam int unsigned BANK_BIT_IDX  = 4;

  localparam logic [ADDR_W-1:0] BANK_PORT = 16'h1fd0;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_SIGNAL = 2'd2;

  localparam logic [1:0] QUARTER_IO = 2'd0;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              dma_access;
    logic              signal_level;
  } pvio_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              io_forward;
    logic              io_is_write;
    logic              io_dma;
    logic [ADDR_W-1:0] io_address;
    logic [DATA_W-1:0] io_data;
  } pvio_out_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic exec;
    logic capture_rd;
  } pvio_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;
    logic plane_read;
    logic out_free;
    logic clr_last;
  } pvio_status_t;

endpackage

// ----- rtl/core/plane_vram_io_decoder.sv -----
// Top level of the plane memory I/O decoder: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o   | in_data_i  (pvio_in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (pvio_out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (turbo banking enable)
//
// An item passes through accept and execute; a plane read adds a capture step, set by the
// registered read port of the plane memory. Signal updates produce no result.
// After reset the plane memory is swept to zero, one row per cycle, over all
// 2 * 2^ceil(log2(PLANE_BYTES)) rows (32768 at the default), with in_stall_o high.
// A result waits in the output register; a stalled output holds the next
// item in execute only when that item owes a result.
module plane_vram_io_decoder #(
  parameter int unsigned PLANE_BYTES = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pvio_pkg::pvio_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pvio_pkg::pvio_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import pvio_pkg::*;

  pvio_cmd_t    cmd;
  pvio_status_t status;

  assign cfg_ready_o = 1'b1;

  pvio_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pvio_dp #(
    .PLANE_BYTES (PLANE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/pvio_ctrl.sv -----
// Sequencing state machine for the plane memory I/O decoder.
module pvio_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pvio_pkg::pvio_status_t status_i,
  output pvio_pkg::pvio_cmd_t    cmd_o
);
  import pvio_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_READ  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o.clr_step   = (state_q == ST_CLEAR);
    cmd_o.load_item  = (state_q == ST_IDLE) && in_valid_i;
    // hold in execute while a result is owed and the output slot is busy
    cmd_o.exec       = (state_q == ST_EXEC) && (!status_i.has_result || status_i.out_free);
    cmd_o.capture_rd = (state_q == ST_READ);
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_o.exec) state_d = status_i.plane_read ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_step |-> !(cmd_o.exec || cmd_o.load_item || cmd_o.capture_rd))
    else $error("clear sweep overlaps item processing");

  a_capture_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture_rd |-> $past(cmd_o.exec && status_i.plane_read))
    else $error("read capture without a preceding plane read");

  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec && status_i.has_result) |-> status_i.out_free)
    else $error("result produced into a busy output slot");

endmodule

// ----- rtl/core/pvio_dp.sv -----
// Datapath: item register, mode state, plane memory and output register.
module pvio_dp #(
  parameter int unsigned PLANE_BYTES = 16384
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pvio_pkg::pvio_in_t     in_data_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_data_i,
  input  pvio_pkg::pvio_cmd_t    cmd_i,
  output pvio_pkg::pvio_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output pvio_pkg::pvio_out_t    out_data_o
);
  import pvio_pkg::*;

  localparam int unsigned OFS_W     = $clog2(PLANE_BYTES);
  localparam int unsigned ROW_W     = OFS_W + 1;
  localparam int unsigned MEM_ROWS  = 2 ** ROW_W;
  localparam int unsigned RED_STEPS = $clog2((16384 + PLANE_BYTES - 1) / PLANE_BYTES);

  // Reduce the 14-bit plane offset modulo PLANE_BYTES by restoring subtraction.
  function automatic logic [OFS_W-1:0] plane_ofs(input logic [IN_OFS_W-1:0] a);
    logic [IN_OFS_W:0] r;
    r = {1'b0, a};
    for (int i = RED_STEPS - 1; i >= 0; i--) begin
      if (r >= ((IN_OFS_W+1)'(PLANE_BYTES) << i)) begin
        r = r - ((IN_OFS_W+1)'(PLANE_BYTES) << i);
      end
    end
    return r[OFS_W-1:0];
  endfunction

  pvio_in_t  item_q;
  pvio_out_t out_q, out_d;
  logic      out_valid_q;
  logic      turbo_q, sim_q, last_lvl_q, bank_q;
  logic [ROW_W-1:0] clr_cnt_q;

  logic [NUM_PLANES-1:0][DATA_W-1:0] mem_q [MEM_ROWS];
  logic [NUM_PLANES-1:0][DATA_W-1:0] rd_q;

  logic [1:0]            quarter;
  logic [1:0]            sel;
  logic [NUM_PLANES-1:0] sel_mask;
  logic                  is_write, is_read, is_signal, plane_quarter;
  logic [OFS_W-1:0]      ofs;
  logic [ROW_W-1:0]      mem_addr;
  logic [NUM_PLANES-1:0] mem_we;
  logic [DATA_W-1:0]     mem_wdata;
  logic                  mem_re;
  logic                  load_out;

  assign quarter       = item_q.address[QUARTER_LSB +: 2];
  assign plane_quarter = (quarter != QUARTER_IO);
  assign sel           = quarter - 2'd1;
  assign sel_mask      = NUM_PLANES'(3'b001 << sel);
  assign is_write      = (item_q.action == ACT_WRITE);
  assign is_read       = (item_q.action == ACT_READ);
  assign is_signal     = (item_q.action == ACT_SIGNAL);
  assign ofs           = plane_ofs(item_q.address[IN_OFS_W-1:0]);

  assign status_o.has_result = is_write || is_read;
  assign status_o.plane_read = is_read && plane_quarter;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.clr_last   = &clr_cnt_q;

  always_comb begin
    mem_addr  = {turbo_q & bank_q, ofs};
    mem_we    = '0;
    mem_wdata = item_q.write_data;
    if (cmd_i.clr_step) begin
      mem_addr  = clr_cnt_q;
      mem_we    = '1;
      mem_wdata = '0;
    end else if (cmd_i.exec && is_write) begin
      if (plane_quarter) begin
        mem_we = sim_q ? ~sel_mask : sel_mask;
      end else if (sim_q) begin
        mem_we = '1;
      end
    end
  end

  assign mem_re = cmd_i.exec && status_o.plane_read;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_PLANES; l++) begin
      if (mem_we[l]) mem_q[mem_addr][l] <= mem_wdata;
    end
    if (mem_re) rd_q <= mem_q[mem_addr];
  end

  always_comb begin
    out_d    = '0;
    load_out = 1'b0;
    if (cmd_i.capture_rd) begin
      load_out        = 1'b1;
      out_d.read_data = rd_q[sel];
    end else if (cmd_i.exec && status_o.has_result && !status_o.plane_read) begin
      load_out = 1'b1;
      // forward unless the write lands on the planes
      if (is_read || !sim_q) begin
        if (!(is_write && plane_quarter)) begin
          out_d.io_forward  = 1'b1;
          out_d.io_is_write = is_write;
          out_d.io_dma      = item_q.dma_access;
          out_d.io_address  = item_q.address;
          out_d.io_data     = is_write ? item_q.write_data : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (load_out) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      turbo_q     <= 1'b0;
      sim_q       <= 1'b0;
      last_lvl_q  <= 1'b0;
      bank_q      <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) turbo_q <= cfg_data_i;
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + ROW_W'(1);
      if (cmd_i.exec) begin
        if (is_signal) begin
          if (last_lvl_q && !item_q.signal_level) sim_q <= 1'b1;
          last_lvl_q <= item_q.signal_level;
        end else if (is_read) begin
          sim_q <= 1'b0;
        end else if (is_write && !plane_quarter && !sim_q && turbo_q &&
                     item_q.address == BANK_PORT) begin
          bank_q <= item_q.write_data[BANK_BIT_IDX];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.exec || cmd_i.capture_rd))
    else $error("output raised without an executed item");

  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> !out_valid_q)
    else $error("result pending during memory clear");

  a_sim_write_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_write && sim_q && plane_quarter) |-> $countones(mem_we) == 2)
    else $error("simultaneous write must hit two planes");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the plane memory I/O decoder: directed table plus random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pvio_pkg::*;

  localparam int unsigned PLANE_BYTES  = 16384;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam longint      RUN_LIMIT_NS = 64'd5_000_000;

  // Action code that the block ignores
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_RARE, STALL_PERIODIC} stall_mode_e;

  typedef struct packed {
    bit        is_cfg;
    bit        cfg_val;
    pvio_in_t  item;
    bit        typed;
    pvio_out_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  pvio_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  pvio_out_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i  = 1'b0;

  // Shadow copy of the decoder state
  logic [DATA_W-1:0] plane_mem [2*NUM_PLANES*PLANE_BYTES];
  bit simul_mode;
  bit signal_last;
  bit bank_sel;
  bit turbo_en;

  pvio_out_t   pending_results[$];
  dir_row_t    dir_rows[$];
  int          mismatches;
  int          accepted_items;
  int          burst_left;
  int          stall_left;
  stall_mode_e stall_mode;

  plane_vram_io_decoder #(
    .PLANE_BYTES(PLANE_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("plane_vram_io_decoder verification failed");
    $finish;
  end

  function automatic pvio_in_t mk_in(logic [1:0] act, logic [ADDR_W-1:0] addr,
                                     logic [DATA_W-1:0] wd, bit dma, bit lvl);
    pvio_in_t it;
    it.action       = act;
    it.address      = addr;
    it.write_data   = wd;
    it.dma_access   = dma;
    it.signal_level = lvl;
    return it;
  endfunction

  function automatic pvio_out_t mk_out(logic [DATA_W-1:0] rd, bit fwd, bit wr, bit dma,
                                       logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wd);
    pvio_out_t res;
    res.read_data   = rd;
    res.io_forward  = fwd;
    res.io_is_write = wr;
    res.io_dma      = dma;
    res.io_address  = addr;
    res.io_data     = wd;
    return res;
  endfunction

  function automatic int plane_cell(int plane, logic [ADDR_W-1:0] addr);
    int bank;
    bank = (turbo_en && bank_sel) ? 1 : 0;
    return (bank * NUM_PLANES + plane) * PLANE_BYTES
           + (int'(addr[IN_OFS_W-1:0]) % PLANE_BYTES);
  endfunction

  // Update the shadow state for one access; return 1 when it owes a result.
  function automatic bit decode_access(input pvio_in_t it, output pvio_out_t res);
    logic [1:0] quarter;
    quarter = it.address[ADDR_W-1:QUARTER_LSB];
    res = '0;
    case (it.action)
      ACT_SIGNAL: begin
        if (signal_last && !it.signal_level) simul_mode = 1'b1;
        signal_last = it.signal_level;
        return 1'b0;
      end
      ACT_WRITE: begin
        if (simul_mode) begin
          // Quarter 00 hits all planes, any other skips its own plane
          for (int p = 0; p < NUM_PLANES; p++) begin
            if (quarter == QUARTER_IO || p != int'(quarter) - 1)
              plane_mem[plane_cell(p, it.address)] = it.write_data;
          end
        end else if (quarter != QUARTER_IO) begin
          plane_mem[plane_cell(int'(quarter) - 1, it.address)] = it.write_data;
        end else begin
          if (turbo_en && it.address == BANK_PORT) bank_sel = it.write_data[BANK_BIT_IDX];
          res = mk_out('0, 1'b1, 1'b1, it.dma_access, it.address, it.write_data);
        end
        return 1'b1;
      end
      ACT_READ: begin
        simul_mode = 1'b0;
        if (quarter != QUARTER_IO)
          res.read_data = plane_mem[plane_cell(int'(quarter) - 1, it.address)];
        else
          res = mk_out('0, 1'b1, 1'b0, it.dma_access, it.address, '0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic idle_in(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Send in bursts with random gaps, some bursts long
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle_in(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8));
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_item(pvio_in_t it, bit typed, pvio_out_t want);
    pvio_out_t res;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_access(it, res)) pending_results.push_back(typed ? want : res);
    if (it.action != ACT_IGNORED) accepted_items++;
    pace();
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_turbo(bit value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    turbo_en = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic row(pvio_in_t it);
    dir_rows.push_back('{1'b0, 1'b0, it, 1'b0, '0});
  endtask

  task automatic row_typed(pvio_in_t it, pvio_out_t want);
    dir_rows.push_back('{1'b0, 1'b0, it, 1'b1, want});
  endtask

  task automatic row_cfg(bit value);
    dir_rows.push_back('{1'b1, value, '0, 1'b0, '0});
  endtask

  function automatic logic [ADDR_W-1:0] plane_addr();
    logic [IN_OFS_W-1:0] ofs;
    // Keep most offsets on a few hot bytes so reads see earlier writes
    case ($urandom_range(0, 3))
      0:       ofs = IN_OFS_W'($urandom);
      1:       ofs = IN_OFS_W'(16'h3ff8 + $urandom_range(0, 7));
      default: ofs = IN_OFS_W'($urandom_range(0, 7));
    endcase
    return {2'($urandom_range(1, 3)), ofs};
  endfunction

  task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(10, 120);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_COIN:  out_stall_i <= 1'($urandom_range(0, 1));
      STALL_RARE:  out_stall_i <= ($urandom_range(0, 7) == 0);
      default:     out_stall_i <= ((stall_left % 5) < 3);
    endcase
  end

  always @(posedge clk_i) begin : result_check
    pvio_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", ADDR_W'(want.read_data), ADDR_W'(out_data_o.read_data));
        check_field("io_forward", ADDR_W'(want.io_forward), ADDR_W'(out_data_o.io_forward));
        check_field("io_is_write", ADDR_W'(want.io_is_write),
                    ADDR_W'(out_data_o.io_is_write));
        check_field("io_dma", ADDR_W'(want.io_dma), ADDR_W'(out_data_o.io_dma));
        check_field("io_address", want.io_address, out_data_o.io_address);
        check_field("io_data", ADDR_W'(want.io_data), ADDR_W'(out_data_o.io_data));
      end
    end
  end

  initial begin : stimulus
    pvio_in_t  it;
    pvio_out_t blank;
    bit        phase_turbo[4];
    int        target;
    int        pick;

    blank       = '0;
    phase_turbo = '{1'b0, 1'b1, 1'b0, 1'b1};
    foreach (plane_mem[i]) plane_mem[i] = '0;

    // Zeroed memory and forwarding first, then simultaneous mode, then banking
    row_cfg(1'b0);
    row_typed(mk_in(ACT_READ, 16'h4000, 8'h00, 1'b0, 1'b0), blank);
    row_typed(mk_in(ACT_READ, 16'hffff, 8'h00, 1'b0, 1'b0), blank);
    row_typed(mk_in(ACT_READ, 16'h0000, 8'h00, 1'b1, 1'b0),
              mk_out(8'h00, 1'b1, 1'b0, 1'b1, 16'h0000, 8'h00));
    row_typed(mk_in(ACT_WRITE, 16'hffff, 8'hff, 1'b1, 1'b1), blank);
    row(mk_in(ACT_READ, 16'hffff, 8'h00, 1'b1, 1'b0));
    row_typed(mk_in(ACT_WRITE, 16'h0123, 8'ha5, 1'b0, 1'b0),
              mk_out(8'h00, 1'b1, 1'b1, 1'b0, 16'h0123, 8'ha5));
    row_typed(mk_in(ACT_WRITE, BANK_PORT, 8'h10, 1'b0, 1'b0),
              mk_out(8'h00, 1'b1, 1'b1, 1'b0, BANK_PORT, 8'h10));
    row(mk_in(ACT_SIGNAL, 16'h0000, 8'h00, 1'b0, 1'b1));
    row(mk_in(ACT_SIGNAL, 16'h0000, 8'h00, 1'b0, 1'b0));
    row(mk_in(ACT_WRITE, 16'h8001, 8'h3c, 1'b0, 1'b0));
    row(mk_in(ACT_WRITE, 16'h0002, 8'h77, 1'b1, 1'b0));
    row(mk_in(ACT_IGNORED, 16'h4001, 8'h55, 1'b1, 1'b1));
    row(mk_in(ACT_READ, 16'h4001, 8'h00, 1'b0, 1'b0));
    row(mk_in(ACT_READ, 16'hc001, 8'h00, 1'b0, 1'b0));
    row(mk_in(ACT_READ, 16'h8001, 8'h00, 1'b0, 1'b0));
    row(mk_in(ACT_READ, 16'hc002, 8'h00, 1'b0, 1'b0));
    row(mk_in(ACT_SIGNAL, 16'h0000, 8'h00, 1'b0, 1'b0));
    row_cfg(1'b1);
    row(mk_in(ACT_WRITE, BANK_PORT, 8'h10, 1'b0, 1'b0));
    row(mk_in(ACT_WRITE, 16'h4005, 8'h99, 1'b0, 1'b0));
    row(mk_in(ACT_READ, 16'h4005, 8'h00, 1'b0, 1'b0));
    row(mk_in(ACT_WRITE, BANK_PORT, 8'hef, 1'b1, 1'b0));
    row(mk_in(ACT_READ, 16'h4005, 8'h00, 1'b0, 1'b0));
    row(mk_in(ACT_SIGNAL, 16'h0000, 8'h00, 1'b0, 1'b1));
    row(mk_in(ACT_SIGNAL, 16'h0000, 8'h00, 1'b0, 1'b0));
    row(mk_in(ACT_WRITE, BANK_PORT, 8'h10, 1'b0, 1'b0));
    row(mk_in(ACT_READ, BANK_PORT, 8'h00, 1'b1, 1'b0));

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_turbo(dir_rows[i].cfg_val);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    foreach (phase_turbo[ph]) begin
      write_turbo(phase_turbo[ph]);
      target = accepted_items + PHASE_ITEMS;
      while (accepted_items < target) begin
        it   = mk_in(ACT_WRITE, 16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // Falling edge on the signal line enters simultaneous mode
          it.action       = ACT_SIGNAL;
          it.signal_level = 1'b1;
          send_item(it, 1'b0, blank);
          it.signal_level = 1'b0;
        end else if (pick < 40) begin
          it.address = plane_addr();
        end else if (pick < 72) begin
          it.action  = ACT_READ;
          it.address = plane_addr();
        end else if (pick < 80) begin
          it.action = ACT_SIGNAL;
        end else if (pick < 88) begin
          it.address = BANK_PORT;
        end else if (pick < 96) begin
          it.action = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
          it.address[ADDR_W-1:QUARTER_LSB] = QUARTER_IO;
        end else begin
          it.action = ACT_IGNORED;
        end
        send_item(it, 1'b0, blank);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("plane_vram_io_decoder verification clean");
    end else begin
      $display("plane_vram_io_decoder verification failed");
    end
    $finish;
  end

endmodule
